FILE: design/dlkl_pkg.sv
`timescale 1ns / 1ps
package dlkl_pkg;

  typedef enum logic [3:0] {
    ACT_INS_HEAD  = 4'd0,
    ACT_INS_TAIL  = 4'd1,
    ACT_INS_AFTER = 4'd2,
    ACT_DEL_HEAD  = 4'd3,
    ACT_DEL_TAIL  = 4'd4,
    ACT_DEL_KEY   = 4'd5,
    ACT_SEARCH    = 4'd6,
    ACT_LIST_FWD  = 4'd7,
    ACT_LIST_BACK = 4'd8
  } action_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_READ, S_CHECK, S_LINK, S_UNLINK, S_LIST, S_EMIT, S_DRAIN
  } state_e;

  // Datapath operations chosen by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SET_HEAD, OP_SET_TAIL, OP_SET_FIND, OP_READ,
    OP_ADVANCE, OP_INSERT, OP_UNLINK, OP_RESULT, OP_LIST_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] status;
    logic       use_key;
    logic       last;
    logic       fwd;
  } cmd_t;

  typedef struct packed {
    logic    empty;
    logic    full;
    logic    ptr_null;
    logic    match;
    logic    steps_done;
    logic    out_busy;
    action_e action;
  } stat_t;

endpackage

FILE: design/dlkl_datapath.sv
`timescale 1ns / 1ps
module dlkl_datapath #(
  parameter int CAPACITY = 16,
  parameter int IW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           action_i,
  input  logic signed [31:0]   key_i,
  input  logic signed [31:0]   anchor_key_i,
  input  dlkl_pkg::cmd_t       cmd_i,
  output dlkl_pkg::stat_t      stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic signed [31:0]   key_out_o,
  output logic                 last_o
);
  import dlkl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam logic [IW-1:0] NULLI = IW'(CAPACITY);

  logic [31:0]   mem_key [CAPACITY];
  logic [IW-1:0] mem_nx  [CAPACITY];
  logic [IW-1:0] mem_pv  [CAPACITY];
  logic [CAPACITY-1:0] used_q;
  logic [IW-1:0] head_q, tail_q, cnt_q, ptr_q, steps_q;
  logic [3:0]    act_q;
  logic [31:0]   key_q, anc_q;
  // Registered fields of the node under the pointer.
  logic [31:0]   rkey_q;
  logic [IW-1:0] rnx_q, rpv_q;
  logic          ov_q, olast_q;
  logic [1:0]    ost_q;
  logic [31:0]   okey_q;

  // Lowest free slot.
  logic [IW-1:0] free_idx;
  always_comb begin
    free_idx = NULLI;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = IW'(i);
    end
  end

  logic [31:0] cmp_key;
  assign cmp_key = (act_q == ACT_INS_AFTER) ? anc_q : key_q;

  // A listed node is the final one when its onward link is null or the
  // walk has reached its step bound.
  logic list_end;
  assign list_end = ((cmd_i.fwd ? rnx_q : rpv_q) == NULLI) ||
                    (steps_q == IW'(CAPACITY - 1));

  assign stat_o.empty      = (head_q == NULLI);
  assign stat_o.full       = (cnt_q == NULLI);
  assign stat_o.ptr_null   = (ptr_q >= NULLI);
  assign stat_o.match      = (rkey_q == cmp_key);
  assign stat_o.steps_done = (steps_q == NULLI);
  assign stat_o.out_busy   = ov_q;
  assign stat_o.action     = action_e'(act_q);

  logic [AW-1:0] pa, na, va, fa;
  assign pa = ptr_q[AW-1:0];
  assign na = rnx_q[AW-1:0];
  assign va = rpv_q[AW-1:0];
  assign fa = free_idx[AW-1:0];

  // Node memories: written by link updates, read at the pointer.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_READ: begin
        rkey_q <= mem_key[pa];
        rnx_q  <= mem_nx[pa];
        rpv_q  <= mem_pv[pa];
      end
      OP_INSERT: begin
        mem_key[fa] <= key_q;
        if (head_q == NULLI) begin
          mem_nx[fa] <= NULLI;
          mem_pv[fa] <= NULLI;
        end else if (act_q == ACT_INS_HEAD) begin
          mem_nx[fa] <= head_q;
          mem_pv[fa] <= NULLI;
          mem_pv[head_q[AW-1:0]] <= free_idx;
        end else if (act_q == ACT_INS_TAIL) begin
          mem_nx[fa] <= NULLI;
          mem_pv[fa] <= tail_q;
          mem_nx[tail_q[AW-1:0]] <= free_idx;
        end else begin
          mem_nx[fa] <= rnx_q;
          mem_pv[fa] <= ptr_q;
          mem_nx[pa] <= free_idx;
          if (rnx_q != NULLI) mem_pv[na] <= free_idx;
        end
      end
      OP_UNLINK: begin
        if (rpv_q != NULLI) mem_nx[va] <= rnx_q;
        if (rnx_q != NULLI) mem_pv[na] <= rpv_q;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      head_q  <= NULLI;
      tail_q  <= NULLI;
      cnt_q   <= '0;
      ptr_q   <= NULLI;
      steps_q <= '0;
      act_q   <= '0;
      key_q   <= '0;
      anc_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.op == OP_RESULT || cmd_i.op == OP_LIST_OUT) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          act_q <= action_i;
          key_q <= key_i;
          anc_q <= anchor_key_i;
        end
        OP_SET_HEAD: begin
          ptr_q <= head_q;
          steps_q <= '0;
        end
        OP_SET_TAIL: begin
          ptr_q <= tail_q;
          steps_q <= '0;
        end
        OP_SET_FIND: begin
          ptr_q <= head_q;
          steps_q <= '0;
        end
        OP_ADVANCE: begin
          ptr_q <= cmd_i.fwd ? rnx_q : rpv_q;
          steps_q <= steps_q + 1'b1;
        end
        OP_INSERT: begin
          used_q[fa] <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
          if (head_q == NULLI) begin
            head_q <= free_idx;
            tail_q <= free_idx;
          end else if (act_q == ACT_INS_HEAD) begin
            head_q <= free_idx;
          end else if (act_q == ACT_INS_TAIL) begin
            tail_q <= free_idx;
          end else if (rnx_q == NULLI) begin
            tail_q <= free_idx;
          end
        end
        OP_UNLINK: begin
          used_q[pa] <= 1'b0;
          cnt_q <= cnt_q - 1'b1;
          if (rpv_q == NULLI) head_q <= rnx_q;
          if (rnx_q == NULLI) tail_q <= rpv_q;
        end
        default: ;
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESULT || cmd_i.op == OP_LIST_OUT) begin
      ost_q   <= cmd_i.status;
      okey_q  <= cmd_i.use_key ? rkey_q : 32'd0;
      olast_q <= (cmd_i.op == OP_LIST_OUT) ? list_end : cmd_i.last;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o    = ost_q;
  assign key_out_o   = okey_q;
  assign last_o      = olast_q;
endmodule

FILE: design/dlkl_ctrl.sv
`timescale 1ns / 1ps
module dlkl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dlkl_pkg::stat_t stat_i,
  output dlkl_pkg::cmd_t  cmd_o
);
  import dlkl_pkg::*;

  state_e state_q, state_d;
  logic   dk_phase_q, dk_phase_d;
  logic   dk_walk_q, dk_walk_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      dk_phase_q <= 1'b0;
      dk_walk_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      dk_phase_q <= dk_phase_d;
      dk_walk_q  <= dk_walk_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    dk_phase_d = dk_phase_q;
    dk_walk_d  = dk_walk_q;
    cmd_o      = '{op: OP_NONE, status: ST_OK, use_key: 1'b0, last: 1'b1, fwd: 1'b1};
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !stat_i.out_busy;
        if (in_valid_i && !stat_i.out_busy) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        dk_phase_d = 1'b0;
        dk_walk_d = 1'b0;
        case (stat_i.action)
          ACT_INS_HEAD, ACT_INS_TAIL: begin
            if (stat_i.full) begin
              cmd_o.op = OP_RESULT;
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.op = OP_NONE;
              state_d  = S_LINK;
            end
          end
          ACT_INS_AFTER, ACT_SEARCH: begin
            if (stat_i.action == ACT_INS_AFTER && stat_i.full) begin
              cmd_o.op = OP_RESULT;
              cmd_o.status = ST_FULL;
            end else if (stat_i.empty) begin
              cmd_o.op = OP_RESULT;
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.op = OP_SET_FIND;
              state_d  = S_READ;
            end
          end
          ACT_DEL_HEAD, ACT_DEL_KEY, ACT_LIST_FWD: begin
            if (stat_i.empty) begin
              cmd_o.op = OP_RESULT;
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.op = OP_SET_HEAD;
              state_d  = S_READ;
            end
          end
          ACT_DEL_TAIL, ACT_LIST_BACK: begin
            if (stat_i.empty) begin
              cmd_o.op = OP_RESULT;
              cmd_o.status = ST_EMPTY;
            end else begin
              cmd_o.op = OP_SET_TAIL;
              state_d  = S_READ;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_READ: begin
        // A walk ends at a null link or after CAPACITY steps.
        if (stat_i.ptr_null || stat_i.steps_done) begin
          if (stat_i.action == ACT_LIST_FWD || stat_i.action == ACT_LIST_BACK) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = OP_RESULT;
            cmd_o.status = ST_NOTFOUND;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_READ;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        case (stat_i.action)
          ACT_DEL_HEAD, ACT_DEL_TAIL: state_d = S_UNLINK;
          ACT_LIST_FWD, ACT_LIST_BACK: state_d = S_LIST;
          ACT_DEL_KEY: begin
            if (stat_i.match) begin
              state_d = S_UNLINK;
            end else if (!dk_phase_q) begin
              // Head missed: try the tail next.
              cmd_o.op = OP_SET_TAIL;
              dk_phase_d = 1'b1;
              state_d = S_READ;
            end else if (!dk_walk_q) begin
              // Tail missed: walk from the head.
              cmd_o.op = OP_SET_FIND;
              dk_walk_d = 1'b1;
              state_d = S_READ;
            end else begin
              cmd_o.op = OP_ADVANCE;
              state_d = S_READ;
            end
          end
          default: begin
            if (stat_i.match) begin
              state_d = (stat_i.action == ACT_SEARCH) ? S_EMIT : S_LINK;
            end else begin
              cmd_o.op = OP_ADVANCE;
              state_d = S_READ;
            end
          end
        endcase
      end
      S_EMIT: begin
        cmd_o.op = OP_RESULT;
        cmd_o.use_key = 1'b1;
        state_d = S_IDLE;
      end
      S_LINK: begin
        cmd_o.op = OP_INSERT;
        state_d  = S_DRAIN;
      end
      S_UNLINK: begin
        cmd_o.op = OP_UNLINK;
        state_d  = S_DRAIN;
      end
      S_DRAIN: begin
        cmd_o.op = OP_RESULT;
        state_d  = S_IDLE;
      end
      S_LIST: begin
        // One listed word per node; hold while the output is occupied.
        cmd_o.fwd = (stat_i.action == ACT_LIST_FWD);
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_LIST_OUT;
          cmd_o.use_key = 1'b1;
          cmd_o.last = 1'b0;
          state_d = S_LIST;
          dk_phase_d = 1'b1;
        end
        if (dk_phase_q) begin
          cmd_o.op = OP_ADVANCE;
          dk_phase_d = 1'b0;
          state_d = S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

FILE: design/doubly_linked_key_list.sv
`timescale 1ns / 1ps
// Doubly linked list of signed keys in a pool of CAPACITY nodes; each input word
// is one action and gives one result word (a listing gives one word per key,
// the last one marked; an undefined action code gives none). Search, insert-after
// and delete-by-key walk the list one node at a time through the node memory read
// port; listings also wait on output stalls.
module doubly_linked_key_list #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         action_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] anchor_key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] key_out_o,
  output logic               last_o
);
  import dlkl_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  list_last;

  dlkl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  dlkl_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i, .rst_ni, .action_i, .key_i, .anchor_key_i,
    .cmd_i(cmd), .stat_o(stat),
    .out_valid_o, .out_ready_i, .status_o, .key_out_o, .last_o(list_last)
  );

  assign last_o = list_last;
endmodule

FILE: tb/tb_doubly_linked_key_list.sv
`timescale 1ns / 1ps
module tb_doubly_linked_key_list;
  import dlkl_pkg::*;

  localparam int CAP = 16;
  localparam int NIL = CAP;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key_out;
    logic               last;
  } result_t;

  // Scoreboard: keeps a shadow copy of the list and the queue of results
  // each accepted word should produce.
  class list_scoreboard;
    logic signed [31:0] keys[CAP];
    int nxt[CAP];
    int prv[CAP];
    bit used[CAP];
    int head;
    int tail;
    int count;
    result_t pending[$];
    int errors;

    function void clear();
      for (int i = 0; i < CAP; i++) begin
        used[i] = 0;
        nxt[i] = NIL;
        prv[i] = NIL;
        keys[i] = '0;
      end
      head = NIL;
      tail = NIL;
      count = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void push(logic [1:0] st, logic signed [31:0] k, logic l);
      result_t r;
      r.status = st;
      r.key_out = k;
      r.last = l;
      pending.push_back(r);
    endfunction

    function int find_key(logic signed [31:0] k);
      int p;
      int n;
      p = head;
      n = 0;
      while (p != NIL && n < CAP) begin
        if (keys[p] == k) return p;
        p = nxt[p];
        n++;
      end
      return NIL;
    endfunction

    function int grab(logic signed [31:0] k);
      for (int i = 0; i < CAP; i++) begin
        if (!used[i]) begin
          used[i] = 1;
          keys[i] = k;
          nxt[i] = NIL;
          prv[i] = NIL;
          count++;
          return i;
        end
      end
      return NIL;
    endfunction

    function void unlink(int p);
      if (prv[p] != NIL) nxt[prv[p]] = nxt[p];
      else head = nxt[p];
      if (nxt[p] != NIL) prv[nxt[p]] = prv[p];
      else tail = prv[p];
      used[p] = 0;
      nxt[p] = NIL;
      prv[p] = NIL;
      count--;
    endfunction

    // Applies one accepted word to the shadow list.
    function void note_word(logic [3:0] act, logic signed [31:0] k,
                            logic signed [31:0] anchor);
      bit empty;
      int p;
      int q;
      int n;
      empty = (head == NIL);
      case (act)
        ACT_INS_HEAD, ACT_INS_TAIL: begin
          if (count >= CAP) begin
            push(ST_FULL, 0, 1);
          end else begin
            q = grab(k);
            if (empty) begin
              head = q;
              tail = q;
            end else if (act == ACT_INS_HEAD) begin
              nxt[q] = head;
              prv[head] = q;
              head = q;
            end else begin
              prv[q] = tail;
              nxt[tail] = q;
              tail = q;
            end
            push(ST_OK, 0, 1);
          end
        end
        ACT_INS_AFTER: begin
          if (count >= CAP) push(ST_FULL, 0, 1);
          else if (empty) push(ST_EMPTY, 0, 1);
          else begin
            p = find_key(anchor);
            if (p == NIL) push(ST_NOTFOUND, 0, 1);
            else begin
              q = grab(k);
              nxt[q] = nxt[p];
              prv[q] = p;
              if (nxt[p] != NIL) prv[nxt[p]] = q;
              else tail = q;
              nxt[p] = q;
              push(ST_OK, 0, 1);
            end
          end
        end
        ACT_DEL_HEAD, ACT_DEL_TAIL: begin
          if (empty) push(ST_EMPTY, 0, 1);
          else begin
            unlink(act == ACT_DEL_HEAD ? head : tail);
            push(ST_OK, 0, 1);
          end
        end
        ACT_DEL_KEY: begin
          if (empty) push(ST_EMPTY, 0, 1);
          else begin
            if (keys[head] == k) p = head;
            else if (keys[tail] == k) p = tail;
            else p = find_key(k);
            if (p == NIL) push(ST_NOTFOUND, 0, 1);
            else begin
              unlink(p);
              push(ST_OK, 0, 1);
            end
          end
        end
        ACT_SEARCH: begin
          if (empty) push(ST_EMPTY, 0, 1);
          else begin
            p = find_key(k);
            if (p == NIL) push(ST_NOTFOUND, 0, 1);
            else push(ST_OK, keys[p], 1);
          end
        end
        ACT_LIST_FWD, ACT_LIST_BACK: begin
          if (empty) push(ST_EMPTY, 0, 1);
          else begin
            p = (act == ACT_LIST_FWD) ? head : tail;
            n = 0;
            while (p != NIL && n < CAP) begin
              q = (act == ACT_LIST_FWD) ? nxt[p] : prv[p];
              push(ST_OK, keys[p], (q == NIL || n == CAP - 1));
              p = q;
              n++;
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask

    task check_word(logic [1:0] st, logic signed [31:0] k, logic l);
      result_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d key=%0d", st, k));
        return;
      end
      e = pending.pop_front();
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, wanted %0d", st, e.status));
      if (k !== e.key_out)
        report_mismatch($sformatf("key_out %0d, wanted %0d", k, e.key_out));
      if (l !== e.last)
        report_mismatch($sformatf("last %0b, wanted %0b", l, e.last));
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [3:0] action_i = '0;
  logic signed [31:0] key_i = '0;
  logic signed [31:0] anchor_key_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [1:0] status_o;
  logic signed [31:0] key_out_o;
  logic last_o;

  list_scoreboard sb;
  bit quiet_tail = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  int cycles = 0;

  doubly_linked_key_list #(.CAPACITY(CAP)) u_top (.*);

  always #10 clk_i = ~clk_i;

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Check every accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(status_o, key_out_o, last_o);
  end

  // Receiver: random stall bursts, a long hold-off on request, none at the end.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
        out_ready_i <= 1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        out_ready_i <= 0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  // Drives one word and waits for it to be accepted.
  task automatic send_word(logic [3:0] act, logic signed [31:0] k,
                           logic signed [31:0] anchor);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    action_i <= act;
    key_i <= k;
    anchor_key_i <= anchor;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(act, k, anchor);
  endtask

  // Picks a key already in the list most of the time, so walks find matches.
  function automatic logic signed [31:0] pick_key();
    int p;
    int n;
    if (sb.head != NIL && $urandom_range(0, 3) != 0) begin
      n = $urandom_range(0, sb.count - 1);
      p = sb.head;
      repeat (n) p = sb.nxt[p];
      return sb.keys[p];
    end
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 20)) - 10;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    logic [3:0] act;
    sb = new();
    sb.clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty-list cases, extremes, duplicates, full pool.
    send_word(ACT_LIST_FWD, 0, 0);
    send_word(ACT_DEL_HEAD, 0, 0);
    send_word(ACT_DEL_TAIL, 0, 0);
    send_word(ACT_DEL_KEY, 1, 0);
    send_word(ACT_SEARCH, 1, 0);
    send_word(ACT_INS_AFTER, 1, 1);
    send_word(ACT_INS_HEAD, 32'sh8000_0000, 0);
    send_word(ACT_DEL_TAIL, 0, 0);
    send_word(ACT_INS_TAIL, 32'sh7fff_ffff, 0);
    send_word(ACT_INS_AFTER, -1, 32'sh7fff_ffff);
    send_word(ACT_INS_AFTER, 5, 12345);
    send_word(ACT_INS_HEAD, -1, 0);
    send_word(ACT_SEARCH, -1, 0);
    send_word(ACT_SEARCH, 7, 0);
    send_word(ACT_DEL_KEY, 7, 0);
    send_word(4'd9, 0, 0);
    send_word(4'd15, -1, -1);
    send_word(ACT_LIST_BACK, 0, 0);
    for (int i = 0; i < 14; i++) send_word(ACT_INS_TAIL, i, 0);
    send_word(ACT_INS_HEAD, 99, 0);
    send_word(ACT_INS_AFTER, 98, 3);
    hold_off = 1;
    send_word(ACT_LIST_FWD, 0, 0);
    send_word(ACT_LIST_BACK, 0, 0);
    send_word(ACT_LIST_FWD, 0, 0);
    send_word(ACT_DEL_KEY, 32'sh7fff_ffff, 0);
    send_word(ACT_DEL_KEY, 5, 0);

    // Random: mostly meaningful actions on keys that exist.
    for (int i = 0; i < 300; i++) begin
      if (i == 260) quiet_tail = 1;
      if ($urandom_range(0, 19) == 0) act = 4'($urandom_range(9, 15));
      else if (sb.count < 4) act = 4'($urandom_range(0, 2));
      else if (sb.count > 13) act = 4'($urandom_range(3, 8));
      else act = 4'($urandom_range(0, 8));
      send_word(act, pick_key(), pick_key());
    end
    in_valid_i <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

FILE: sim.f
design/dlkl_pkg.sv
design/dlkl_datapath.sv
design/dlkl_ctrl.sv
design/doubly_linked_key_list.sv
tb/tb_doubly_linked_key_list.sv
